>>> rtl/sgd_pkg.sv
package sgd_pkg;

    localparam int MaxClasses    = 64;
    localparam int ScoreFracBits = 16;
    localparam int ScoreWidth    = 18;
    localparam int IndexWidth    = 6;
    localparam int CountWidth    = 7;
    localparam int BestWidth     = 17;
    localparam int TolWidth      = 17;
    localparam int TotalWidth    = 24;
    localparam int AddrWidth     = 5;
    localparam int DataWidth     = 64;

    // reset values of the configuration registers
    localparam logic [CountWidth-1:0] ClassCountReset = CountWidth'(64);
    localparam logic [TolWidth-1:0]   SumTolReset     = TolWidth'(656);

    typedef enum logic [1:0] {
        RegClassCount = 2'd0,
        RegIgnoredMask = 2'd1,
        RegRemoveDup = 2'd2,
        RegSumTol = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic [CountWidth-1:0] class_count;
        logic [63:0]           ignored_mask;
        logic                  remove_duplicates;
        logic [TolWidth-1:0]   sum_tolerance;
    } cfg_t;

    typedef struct packed {
        logic signed [ScoreWidth-1:0] score;
        logic                         seq_start;
    } in_t;

    typedef struct packed {
        logic [IndexWidth-1:0] class_index;
        logic [BestWidth-1:0]  best_score;
        logic                  kept;
        logic                  range_error;
        logic                  sum_error;
    } out_t;

endpackage

>>> rtl/sgd_regs.sv
module sgd_regs (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [sgd_pkg::AddrWidth-1:0] paddr,
    input  logic [sgd_pkg::DataWidth-1:0] pwdata,
    output logic [sgd_pkg::DataWidth-1:0] prdata,
    output logic                         pready,
    output sgd_pkg::cfg_t                cfg
);
    import sgd_pkg::*;

    cfg_t       cfg_reg;
    reg_index_t reg_index;
    logic       write_en;

    assign pready    = 1'b1;
    assign reg_index = reg_index_t'(paddr[4:3]);
    assign write_en  = psel && penable && pwrite;
    assign cfg       = cfg_reg;

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.class_count       <= ClassCountReset;
            cfg_reg.ignored_mask      <= 64'd0;
            cfg_reg.remove_duplicates <= 1'b1;
            cfg_reg.sum_tolerance     <= SumTolReset;
        end else if (write_en) begin
            unique case (reg_index)
                RegClassCount:  cfg_reg.class_count       <= pwdata[CountWidth-1:0];
                RegIgnoredMask: cfg_reg.ignored_mask      <= pwdata;
                RegRemoveDup:   cfg_reg.remove_duplicates <= pwdata[0];
                RegSumTol:      cfg_reg.sum_tolerance     <= pwdata[TolWidth-1:0];
            endcase
        end
    end

    // read back
    always_comb begin
        unique case (reg_index)
            RegClassCount:  prdata = DataWidth'(cfg_reg.class_count);
            RegIgnoredMask: prdata = cfg_reg.ignored_mask;
            RegRemoveDup:   prdata = DataWidth'(cfg_reg.remove_duplicates);
            RegSumTol:      prdata = DataWidth'(cfg_reg.sum_tolerance);
        endcase
    end

endmodule

>>> rtl/sequence_greedy_decode.sv
// greedy per-step decoder: one class score accepted per cycle
// the result of a row is registered and valid in the cycle after its last score is accepted
// throughput: one score per cycle; a single compare and add per score sets the figure
// the input stalls only while the result register is full and not being taken
// reset (aresetn low, synchronous): row state and previous-class memory cleared,
// registers back to class_count 64, mask 0, duplicate removal on, tolerance 656
module sequence_greedy_decode (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  sgd_pkg::in_t                 s_data,
    output logic                         m_valid,
    input  logic                         m_ready,
    output sgd_pkg::out_t                m_data,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [sgd_pkg::AddrWidth-1:0] paddr,
    input  logic [sgd_pkg::DataWidth-1:0] pwdata,
    output logic [sgd_pkg::DataWidth-1:0] prdata,
    output logic                         pready
);
    import sgd_pkg::*;

    localparam logic signed [ScoreWidth-1:0] ScoreOne = ScoreWidth'(1 << ScoreFracBits);
    localparam logic signed [TotalWidth:0]   ScoreOneDev = (TotalWidth+1)'(1 << ScoreFracBits);
    localparam logic [CountWidth-1:0]        CountMax = CountWidth'(MaxClasses);

    cfg_t cfg;

    sgd_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // row state
    logic [IndexWidth-1:0]        pos_reg;
    logic signed [ScoreWidth-1:0] max_reg;
    logic [IndexWidth-1:0]        arg_reg;
    logic signed [TotalWidth-1:0] total_reg;
    logic                         bad_reg;
    logic [IndexWidth-1:0]        prev_class_reg;
    logic                         prev_valid_reg;
    logic                         m_valid_reg;
    out_t                         m_data_reg;

    logic                         accept;
    logic [IndexWidth-1:0]        pos;
    logic                         prev_valid_eff;
    logic                         first;
    logic                         score_bad;
    logic                         new_max;
    logic signed [ScoreWidth-1:0] max_next;
    logic [IndexWidth-1:0]        arg_next;
    logic signed [TotalWidth-1:0] total_next;
    logic                         bad_next;
    logic [CountWidth-1:0]        count_eff;
    logic                         row_end;
    logic signed [TotalWidth:0]   dev;
    logic [TotalWidth:0]          dev_abs;
    out_t                         result;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // running maximum, sum and range flag including the current score
    always_comb begin
        pos            = s_data.seq_start ? '0 : pos_reg;
        prev_valid_eff = s_data.seq_start ? 1'b0 : prev_valid_reg;
        first          = (pos == '0);
        score_bad      = (s_data.score < 0) || (s_data.score > ScoreOne);
        new_max        = s_data.score > max_reg;
        max_next       = (first || new_max) ? s_data.score : max_reg;
        arg_next       = first ? '0 : (new_max ? pos : arg_reg);
        total_next     = (first ? '0 : total_reg) + TotalWidth'(s_data.score);
        bad_next       = score_bad || (!first && bad_reg);
    end

    // row end against the clipped class count
    always_comb begin
        if (cfg.class_count == '0) begin
            count_eff = CountWidth'(1);
        end else if (cfg.class_count > CountMax) begin
            count_eff = CountMax;
        end else begin
            count_eff = cfg.class_count;
        end
        row_end = ({1'b0, pos} + CountWidth'(1)) >= count_eff;
    end

    // result fields
    always_comb begin
        dev     = {total_next[TotalWidth-1], total_next} - ScoreOneDev;
        dev_abs = dev[TotalWidth] ? unsigned'(-dev) : unsigned'(dev);
        result.class_index = arg_next;
        if (max_next < 0) begin
            result.best_score = '0;
        end else if (max_next > ScoreOne) begin
            result.best_score = BestWidth'(ScoreOne);
        end else begin
            result.best_score = max_next[BestWidth-1:0];
        end
        result.kept = !cfg.ignored_mask[arg_next] &&
                      !(cfg.remove_duplicates && prev_valid_eff &&
                        (prev_class_reg == arg_next));
        result.range_error = bad_next;
        result.sum_error   = dev_abs > (TotalWidth+1)'(cfg.sum_tolerance);
    end

    // state update on each accepted request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg        <= '0;
            max_reg        <= '0;
            arg_reg        <= '0;
            total_reg      <= '0;
            bad_reg        <= 1'b0;
            prev_class_reg <= '0;
            prev_valid_reg <= 1'b0;
        end else if (accept) begin
            max_reg   <= max_next;
            arg_reg   <= arg_next;
            total_reg <= total_next;
            bad_reg   <= bad_next;
            if (row_end) begin
                pos_reg        <= '0;
                prev_class_reg <= arg_next;
                prev_valid_reg <= 1'b1;
            end else begin
                pos_reg        <= pos + IndexWidth'(1);
                prev_valid_reg <= prev_valid_eff;
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept && row_end) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && row_end) begin
            m_data_reg <= result;
        end
    end

`ifndef ASSERT_OFF
    // a new result only follows an accepted score
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !$past(m_valid)) |-> $past(s_valid && s_ready))
        else $error("result appeared without an accepted request");

    // a result waiting on the output is never overwritten
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("stalled result changed");

    // a sequence start that does not close a row clears the previous class
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_data.seq_start && !row_end) |=> !prev_valid_reg)
        else $error("previous class survived a sequence start");

    // the clamped score never exceeds one
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.best_score <= BestWidth'(ScoreOne)))
        else $error("best score above one");
`endif

endmodule
